/* sv/hashed_timing_wheel_defines.svh */
// Assertion macros for the hashed timing wheel.
// Define NO_ASSERTIONS to compile them away.
`ifndef HASHED_TIMING_WHEEL_DEFINES_SVH
`define HASHED_TIMING_WHEEL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define HTW_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hashed timing wheel check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hashed timing wheel check failed");

`else

`define HTW_ASSERT_SAME(lbl, pre, post)
`define HTW_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* sv/htw_pkg.sv */
package htw_pkg;

  // Fixed field widths of the channels.
  localparam int OP_W      = 2;
  localparam int ID_W      = 4;
  localparam int TIMEOUT_W = 20;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_cap;   // capture id and mode, turn the timeout into ticks
    logic div_reload;  // split the ticks into whole turns, then the slot offset
    logic wr_entry;    // write the new timer entry and arm the timer
    logic stop;        // disarm the timer on the input word
    logic scan_start;  // clear the fired set and rewind the scan
    logic scan_en;     // walk the timer table
    logic scan_end;    // advance the current slot and rewind the emitter
    logic emit_en;     // send the fired ids
  } htw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;       // timer id on the input word is in range
    logic div_done;    // no split step pending; after the reload, turns and slot offset are ready
    logic scan_done;   // every table entry processed
    logic emit_done;   // every fired id handed to the output register
  } htw_stat_t;

endpackage

/* sv/htw_in_if.sv */
interface htw_in_if;
  import htw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ID_W-1:0]      timer_id;
  logic [TIMEOUT_W-1:0] timeout_ms;
  logic                 periodic;

  modport source (output valid, operation, timer_id, timeout_ms, periodic, input ready);
  modport sink   (input valid, operation, timer_id, timeout_ms, periodic, output ready);
endinterface

/* sv/htw_out_if.sv */
interface htw_out_if;
  import htw_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] fired_id;
  logic            last;

  modport source (output valid, fired_id, last, input ready);
  modport sink   (input valid, fired_id, last, output ready);
endinterface

/* sv/htw_ram.sv */
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* sv/htw_ctrl.sv */
module htw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [htw_pkg::OP_W-1:0] in_operation,
  output logic                in_ready,
  input  htw_pkg::htw_stat_t  stat,
  output htw_pkg::htw_cmd_t   cmd
);
  import htw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_START: begin
              if (stat.id_ok) begin
                cmd.start_cap = 1'b1;
                state_nxt     = S_DIV1;
              end
            end
            OP_STOP: begin
              cmd.stop = 1'b1;
            end
            OP_TICK: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.div_reload = 1'b1;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.wr_entry = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_en = 1'b1;
        if (stat.emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/htw_dp.sv */
module htw_dp #(
  parameter int SLOTS         = 1024,
  parameter int SLOT_INTERVAL = 1,
  parameter int TIMERS        = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [htw_pkg::ID_W-1:0]      in_timer_id,
  input  logic [htw_pkg::TIMEOUT_W-1:0] in_timeout_ms,
  input  logic                          in_periodic,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htw_pkg::ID_W-1:0]      out_fired_id,
  output logic                          out_last,
  input  htw_pkg::htw_cmd_t             cmd,
  output htw_pkg::htw_stat_t            stat
);
  import htw_pkg::*;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SUM_W      = SLOT_W + 1;
  localparam int MAX_ROUNDS = ((1 << TIMEOUT_W) - 1) / SLOTS;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int IDX_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W      = $clog2(TIMERS + 1);

  // Division by a constant through a rounded-up reciprocal: with a shift of
  // the dividend width plus the ceiling log2 of the divisor the quotient is
  // exact for every dividend of the field.
  localparam int     MUL_W    = TIMEOUT_W + 1;
  localparam int     PROD_W   = TIMEOUT_W + MUL_W;
  localparam int     SH_INT   = TIMEOUT_W + $clog2(SLOT_INTERVAL);
  localparam int     SH_SLOT  = TIMEOUT_W + $clog2(SLOTS);
  localparam longint RCP_INT  = ((longint'(1) << SH_INT) + SLOT_INTERVAL - 1) / SLOT_INTERVAL;
  localparam longint RCP_SLOT = ((longint'(1) << SH_SLOT) + SLOTS - 1) / SLOTS;

  typedef struct packed {
    logic [SLOT_W-1:0]  target;
    logic [ROUND_W-1:0] rounds;
    logic [ROUND_W-1:0] per_rounds;
    logic [SLOT_W-1:0]  per_rem;
    logic               rep;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [SLOT_W-1:0] add_slot(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(SLOTS)) begin
      s = s - SUM_W'(SLOTS);
    end
    return s[SLOT_W-1:0];
  endfunction

  // Control state.
  logic              div_cnt_r, div_cnt_nxt;
  logic [TIMERS-1:0] armed_r, armed_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              proc_v_r, proc_v_nxt;
  logic [TIMERS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload.
  logic [TIMEOUT_W-1:0] ticks_r, ticks_nxt;
  logic [ROUND_W-1:0]   rounds_r, rounds_nxt;
  logic [SLOT_W-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0]     id_r, id_nxt;
  logic                 per_r, per_nxt;
  logic [IDX_W-1:0]     proc_idx_r, proc_idx_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  // Tick conversion and slot split.
  logic [PROD_W-1:0]    int_prod;
  logic [TIMEOUT_W-1:0] int_quo;
  logic [PROD_W-1:0]    slot_prod;
  logic [TIMEOUT_W-1:0] rounds_back;
  logic [TIMEOUT_W-1:0] slot_left;

  // Table access.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_e;
  entry_t           new_e;
  entry_t           upd_e;

  // Emitter.
  logic [IDX_W-1:0]  e_idx;
  logic [TIMERS-1:0] e_onehot;
  logic [TIMERS-1:0] mask_left;
  logic              can_load;

  logic [IDX_W-1:0] in_idx;

  assign in_idx = IDX_W'(in_timer_id);

  assign int_prod    = PROD_W'(in_timeout_ms) * PROD_W'(RCP_INT);
  assign int_quo     = TIMEOUT_W'(int_prod >> SH_INT);
  assign slot_prod   = PROD_W'(ticks_r) * PROD_W'(RCP_SLOT);
  assign rounds_back = TIMEOUT_W'(rounds_r) * TIMEOUT_W'(SLOTS);
  assign slot_left   = ticks_r - rounds_back;

  assign stat.id_ok     = (32'(in_timer_id) < 32'(TIMERS));
  assign stat.div_done  = !div_cnt_r;
  assign stat.scan_done = (scan_cnt_r == CNT_W'(TIMERS)) && !proc_v_r;
  assign stat.emit_done = (emit_cnt_r == CNT_W'(TIMERS));

  // Entry built from the split: rounds = ticks / slots,
  // target = current slot + ticks mod slots.
  always_comb begin
    new_e.target     = add_slot(cur_r, rem_r);
    new_e.rounds     = rounds_r;
    new_e.per_rounds = rounds_r;
    new_e.per_rem    = rem_r;
    new_e.rep        = per_r;
  end

  assign rd_e = entry_t'(ram_rdata);

  assign e_idx     = emit_cnt_r[IDX_W-1:0];
  assign e_onehot  = TIMERS'(1) << e_idx;
  assign mask_left = mask_r & ~e_onehot;
  assign can_load  = !out_valid_r || out_ready;

  always_comb begin
    div_cnt_nxt  = div_cnt_r;
    armed_nxt    = armed_r;
    cur_nxt      = cur_r;
    scan_cnt_nxt = scan_cnt_r;
    proc_v_nxt   = 1'b0;
    mask_nxt     = mask_r;
    emit_cnt_nxt = emit_cnt_r;
    ticks_nxt    = ticks_r;
    rounds_nxt   = rounds_r;
    rem_nxt      = rem_r;
    id_nxt       = id_r;
    per_nxt      = per_r;
    proc_idx_nxt = proc_idx_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we       = 1'b0;
    ram_waddr    = id_r;
    ram_wdata    = ENTRY_W'(new_e);
    ram_raddr    = scan_cnt_r[IDX_W-1:0];
    upd_e        = rd_e;

    // Timeout to ticks on capture, then whole turns, then the slot offset.
    if (cmd.start_cap) begin
      // A timeout below one interval still counts as one tick.
      ticks_nxt = (int_quo == '0) ? TIMEOUT_W'(1) : int_quo;
      id_nxt    = in_idx;
      per_nxt   = in_periodic;
    end else if (cmd.div_reload) begin
      rounds_nxt  = ROUND_W'(slot_prod >> SH_SLOT);
      div_cnt_nxt = 1'b1;
    end else if (div_cnt_r) begin
      rem_nxt     = SLOT_W'(slot_left);
      div_cnt_nxt = 1'b0;
    end

    if (cmd.wr_entry) begin
      ram_we          = 1'b1;
      armed_nxt[id_r] = 1'b1;
    end

    if (cmd.stop && stat.id_ok) begin
      armed_nxt[in_idx] = 1'b0;
    end

    // Table walk: read one entry per cycle, process it the next.
    if (cmd.scan_start) begin
      scan_cnt_nxt = '0;
      mask_nxt     = '0;
    end else if (cmd.scan_en) begin
      if (scan_cnt_r != CNT_W'(TIMERS)) begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = scan_cnt_r[IDX_W-1:0];
      end
      if (proc_v_r && armed_r[proc_idx_r] && (rd_e.target == cur_r)) begin
        ram_waddr = proc_idx_r;
        if (rd_e.rounds != '0) begin
          upd_e.rounds = rd_e.rounds - 1'b1;
          ram_we       = 1'b1;
        end else begin
          mask_nxt[proc_idx_r] = 1'b1;
          if (!rd_e.rep) begin
            armed_nxt[proc_idx_r] = 1'b0;
          end else begin
            upd_e.target = add_slot(cur_r, rd_e.per_rem);
            upd_e.rounds = rd_e.per_rounds;
            // Landing back on this slot: this pass already counts as one turn.
            if ((rd_e.per_rem == '0) && (rd_e.per_rounds != '0)) begin
              upd_e.rounds = rd_e.per_rounds - 1'b1;
            end
            ram_we = 1'b1;
          end
        end
        ram_wdata = ENTRY_W'(upd_e);
      end
    end

    if (cmd.scan_end) begin
      cur_nxt      = (cur_r == SLOT_W'(SLOTS - 1)) ? '0 : (cur_r + 1'b1);
      emit_cnt_nxt = '0;
    end

    // Emitter: ascending index order, one candidate per cycle while not stalled.
    if (cmd.emit_en && !stat.emit_done) begin
      if (mask_r[e_idx]) begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = ID_W'(e_idx);
          out_last_nxt  = (mask_left == '0);
          mask_nxt      = mask_left;
          emit_cnt_nxt  = emit_cnt_r + 1'b1;
        end
      end else begin
        emit_cnt_nxt = emit_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r   <= 1'b0;
      armed_r     <= '0;
      cur_r       <= '0;
      scan_cnt_r  <= '0;
      proc_v_r    <= 1'b0;
      mask_r      <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_cnt_r   <= div_cnt_nxt;
      armed_r     <= armed_nxt;
      cur_r       <= cur_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      proc_v_r    <= proc_v_nxt;
      mask_r      <= mask_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ticks_r    <= ticks_nxt;
    rounds_r   <= rounds_nxt;
    rem_r      <= rem_nxt;
    id_r       <= id_nxt;
    per_r      <= per_nxt;
    proc_idx_r <= proc_idx_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  htw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;

endmodule

/* sv/hashed_timing_wheel.sv */
// Hashed timing wheel with rotation counts. A start word arms a timer with a
// timeout in milliseconds, a stop word disarms it, and a tick word advances the
// wheel by one slot and returns the ids of the timers that expired, in ascending
// order, with last set on the final one; a tick with nothing expiring returns no
// word. Stop and unused operation codes are absorbed in the cycle they are
// accepted, so the next word can follow at once. A start with an id in range
// holds the input while the timeout becomes a tick count by a reciprocal
// multiplication as the word is taken, the ticks are split into whole turns
// and then a slot offset, and the entry is written. A tick holds the input
// until the walk and the drain are done, and longer while the result side
// stalls: the timer table sits in a RAM with a registered read that is walked
// one entry per cycle, and the fired set is then drained through the output
// register one candidate index per cycle, stalling while it is still full.
module hashed_timing_wheel #(
  parameter int SLOTS         = 1024,
  parameter int SLOT_INTERVAL = 1,
  parameter int TIMERS        = 16
) (
  input logic       clk,
  input logic       rst_n,
  htw_in_if.sink    in_ch,
  htw_out_if.source out_ch
);
  import htw_pkg::*;

`include "hashed_timing_wheel_defines.svh"

  htw_cmd_t  cmd;
  htw_stat_t stat;

  // The controller sequences start, stop and tick; it only accepts a new word
  // while idle.
  htw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // The datapath holds the current slot, the armed bits, the timer table,
  // the tick conversion and the output register.
  htw_dp #(
    .SLOTS         (SLOTS),
    .SLOT_INTERVAL (SLOT_INTERVAL),
    .TIMERS        (TIMERS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_timer_id   (in_ch.timer_id),
    .in_timeout_ms (in_ch.timeout_ms),
    .in_periodic   (in_ch.periodic),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_fired_id  (out_ch.fired_id),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .stat          (stat)
  );

  // A pending word that is not the last of its tick means the emitter still
  // has fired ids to send, so the block cannot be idle.
  `HTW_ASSERT_SAME(a_idle_no_partial_tick, in_ch.ready, !out_ch.valid || out_ch.last)

  // A tick always leaves idle for the table walk.
  `HTW_ASSERT_NEXT(a_tick_goes_busy, in_ch.valid && in_ch.ready && in_ch.operation == OP_TICK, !in_ch.ready)

endmodule

/* sim/htw_fire_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the timing wheel, keeps its own copy of the wheel
// and compares every fired id that leaves the block against the oldest one
// that is still owed.
module htw_fire_checker #(
  parameter int SLOTS         = 1024,
  parameter int SLOT_INTERVAL = 1,
  parameter int TIMERS        = 16
) (
  input  logic clk,
  input  logic rst_n,
  htw_in_if    in_ch,
  htw_out_if   out_ch,
  output int   fire_mismatches,
  output int   fires_pending,
  output int   fires_seen
);
  import htw_pkg::*;

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_FIRED = 16;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } fired_word_t;

  fired_word_t fired_due[$];

  logic [SLOT_W-1:0]    wheel_pos;
  logic                 armed     [TIMERS];
  logic [SLOT_W-1:0]    due_slot  [TIMERS];
  logic [TIMEOUT_W-1:0] laps_left [TIMERS];
  logic [TIMEOUT_W-1:0] period    [TIMERS];
  logic                 reloads   [TIMERS];

  initial begin
    fire_mismatches = 0;
    fires_pending   = 0;
    fires_seen      = 0;
  end

  function automatic logic [TIMEOUT_W-1:0] ticks_for(logic [TIMEOUT_W-1:0] ms);
    if (ms < SLOT_INTERVAL) return TIMEOUT_W'(1);
    return TIMEOUT_W'(ms / SLOT_INTERVAL);
  endfunction

  function automatic void place_timer(int t, logic [TIMEOUT_W-1:0] ticks);
    laps_left[t] = TIMEOUT_W'(ticks / SLOTS);
    due_slot[t]  = SLOT_W'((int'(wheel_pos) + int'(ticks)) % SLOTS);
  endfunction

  // One slot interval: every armed timer of the current slot either loses a
  // lap or fires, then the wheel moves on by one slot.
  function automatic void run_tick();
    int n_fired;
    n_fired = 0;
    for (int t = 0; t < TIMERS; t++) begin
      if (armed[t] && due_slot[t] == wheel_pos) begin
        if (laps_left[t] != 0) begin
          laps_left[t]--;
        end else begin
          if (n_fired < MAX_FIRED) begin
            fired_due.push_back('{id: ID_W'(t), last: 1'b0});
            n_fired++;
          end
          if (!reloads[t]) begin
            armed[t] = 1'b0;
          end else begin
            place_timer(t, period[t]);
            // A period of whole turns lands on the slot being scanned, which
            // is not visited again in this tick, so its lap is used up here.
            if (due_slot[t] == wheel_pos && laps_left[t] != 0) laps_left[t]--;
          end
        end
      end
    end
    if (n_fired > 0) fired_due[fired_due.size() - 1].last = 1'b1;
    wheel_pos = SLOT_W'((int'(wheel_pos) + 1) % SLOTS);
  endfunction

  function automatic void note_fault(string msg);
    fire_mismatches++;
    if (fire_mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : watch
    fired_word_t got;
    fired_word_t want;
    int          id;
    if (!rst_n) begin
      wheel_pos = '0;
      for (int t = 0; t < TIMERS; t++) armed[t] = 1'b0;
      fired_due.delete();
    end else begin
      // Results first: a word leaving now can only belong to an earlier tick.
      if (out_ch.valid && out_ch.ready) begin
        got = '{id: out_ch.fired_id, last: out_ch.last};
        fires_seen++;
        if (fired_due.size() == 0) begin
          note_fault($sformatf("unexpected word: id %0d last %0b", got.id, got.last));
        end else begin
          want = fired_due.pop_front();
          if (got.id !== want.id || got.last !== want.last)
            note_fault($sformatf("mismatch: expected id %0d last %0b, got id %0d last %0b",
                                 want.id, want.last, got.id, got.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        id = int'(in_ch.timer_id);
        case (in_ch.operation)
          OP_TICK: run_tick();
          OP_START: begin
            if (id < TIMERS) begin
              period[id]  = ticks_for(in_ch.timeout_ms);
              reloads[id] = in_ch.periodic;
              place_timer(id, period[id]);
              armed[id]   = 1'b1;
            end
          end
          OP_STOP: begin
            if (id < TIMERS) armed[id] = 1'b0;
          end
          default: ;
        endcase
      end
    end
    fires_pending <= fired_due.size();
  end

endmodule

/* sim/tb_hashed_timing_wheel.sv */
`timescale 1ns / 100ps

// Top of the timing wheel bench. It makes the clock, the reset and the word
// streams on both channels, and gives the verdict. All prediction and
// comparison happens in the checker that sits beside the block.
module tb_hashed_timing_wheel;
  import htw_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int SLOT_INTERVAL = 1;
  localparam int TIMERS        = 16;

  // The one operation code the block has no use for.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 300;
  localparam int PRESSURE_AT  = 200;
  localparam int PRESSURE_TICKS = 20;
  localparam int LONG_HOLD    = 400;
  localparam int FINAL_TICKS  = 30;
  localparam int DRAIN_LIMIT  = 20000;
  // Idle wait at the end, well past the time a tick needs for its table walk.
  localparam int SETTLE       = 100;

  logic clk;
  logic rst_n;

  htw_in_if  in_ch();
  htw_out_if out_ch();

  int mismatches;
  int pending;
  int fires_seen;

  // When steady is set, neither side inserts idle cycles.
  bit steady;
  // Set once by the word source to make the result side hold off for a long
  // stretch; the result side clears it when the stretch is over.
  bit hold_request;

  int n_ticks;
  int n_starts;
  int n_stops;
  int n_unused;

  hashed_timing_wheel #(
    .SLOTS        (SLOTS),
    .SLOT_INTERVAL(SLOT_INTERVAL),
    .TIMERS       (TIMERS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  htw_fire_checker #(
    .SLOTS        (SLOTS),
    .SLOT_INTERVAL(SLOT_INTERVAL),
    .TIMERS       (TIMERS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fire_mismatches(mismatches),
    .fires_pending  (pending),
    .fires_seen     (fires_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side. Before every word it draws a random idle stretch, which may be
  // empty, unless a long hold-off has been requested, and then keeps ready high
  // until a word has been taken or a hold-off is requested.
  initial begin : result_side
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && !hold_request);
    end
  end

  // Offers one word after a random idle stretch and returns at the edge that
  // takes it. Valid is left high so that a back-to-back word needs no dip.
  task automatic send_word(input logic [OP_W-1:0]      op,
                           input logic [ID_W-1:0]      id,
                           input logic [TIMEOUT_W-1:0] ms,
                           input logic                 per);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.timer_id   <= id;
    in_ch.timeout_ms <= ms;
    in_ch.periodic   <= per;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_TICK:  n_ticks++;
      OP_START: n_starts++;
      OP_STOP:  n_stops++;
      default:  n_unused++;
    endcase
  endtask

  // Random traffic: mostly ticks and starts so that timers keep expiring.
  // Timeouts are mostly short, some land a whole number of turns ahead so
  // that laps are counted down, and the rest span the full field.
  task automatic send_random_word();
    logic [OP_W-1:0]      op;
    logic [TIMEOUT_W-1:0] ms;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = OP_TICK;
    else if (pick < 80) op = OP_START;
    else if (pick < 94) op = OP_STOP;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 6)      ms = TIMEOUT_W'($urandom_range(0, 24));
    else if (pick < 8) ms = TIMEOUT_W'(SLOTS * $urandom_range(1, 1023) + $urandom_range(0, 8));
    else               ms = TIMEOUT_W'($urandom());
    send_word(op, ID_W'($urandom_range(0, TIMERS - 1)), ms, 1'($urandom_range(0, 1)));
  endtask

  // Waits until the checker owes nothing more or the limit runs out. The first
  // edge lets the checker account for a word taken at the edge it is called from.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_TICK;
    in_ch.timer_id   <= '0;
    in_ch.timeout_ms <= '0;
    in_ch.periodic   <= 1'b0;
    steady       = 1'b0;
    hold_request = 1'b0;
    n_ticks  = 0;
    n_starts = 0;
    n_stops  = 0;
    n_unused = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. An unused code with every field at its maximum and a
    // stop of a timer that is not armed must both leave no trace.
    send_word(OP_UNUSED, '1, '1, 1'b1);
    send_word(OP_STOP, ID_W'(5), '0, 1'b0);
    // Arm every timer one tick ahead. A zero timeout counts as one tick, just
    // like a timeout of one; odd timers are periodic.
    for (int t = 0; t < TIMERS; t++)
      send_word(OP_START, ID_W'(t), (t < 8) ? TIMEOUT_W'(0) : TIMEOUT_W'(1), 1'(t % 2));
    // Restart an armed timer with the largest timeout, and stop another one.
    send_word(OP_START, ID_W'(3), '1, 1'b1);
    send_word(OP_STOP, ID_W'(4), '0, 1'b0);
    // Nothing is due on the first tick; on the second fourteen timers fire,
    // and the periodic ones fire again on the third.
    send_word(OP_TICK, '0, '0, 1'b0);
    send_word(OP_TICK, '1, '1, 1'b1);
    send_word(OP_TICK, '0, '0, 1'b0);
    // A timeout of one whole turn lands on the current slot with one lap,
    // which the next tick consumes without firing.
    send_word(OP_START, ID_W'(4), TIMEOUT_W'(SLOTS), 1'b1);
    send_word(OP_TICK, '0, '0, 1'b0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // One stretch with no idle cycles on either side.
      steady = (i >= 120 && i < 150);
      if (i == PRESSURE_AT) begin
        // Every timer due on each tick while the result side holds off:
        // the block fills up and has to stall its input.
        for (int t = 0; t < TIMERS; t++)
          send_word(OP_START, ID_W'(t), TIMEOUT_W'(1), 1'b1);
        hold_request = 1'b1;
        repeat (PRESSURE_TICKS) send_word(OP_TICK, '0, '0, 1'b0);
        // The source now pauses until every fired id has come out.
        in_ch.valid <= 1'b0;
        wait_drained();
        for (int t = 0; t < TIMERS; t++)
          send_word(OP_STOP, ID_W'(t), '0, 1'b0);
      end
      send_random_word();
    end

    // A closing run of ticks with no idle cycles, after re-arming a few timers
    // at different distances, both one-shot and periodic.
    steady = 1'b1;
    for (int t = 0; t < TIMERS; t++)
      send_word(OP_STOP, ID_W'(t), '0, 1'b0);
    send_word(OP_START, ID_W'(0), TIMEOUT_W'(SLOTS), 1'b0);
    send_word(OP_START, ID_W'(1), TIMEOUT_W'(3), 1'b1);
    send_word(OP_START, ID_W'(2), TIMEOUT_W'(7), 1'b0);
    send_word(OP_START, ID_W'(3), TIMEOUT_W'(2 * SLOTS - 1), 1'b0);
    send_word(OP_START, ID_W'(5), TIMEOUT_W'(SLOTS), 1'b1);
    send_word(OP_START, ID_W'(6), TIMEOUT_W'(0), 1'b1);
    send_word(OP_START, ID_W'(8), TIMEOUT_W'(5), 1'b1);
    repeat (FINAL_TICKS) send_word(OP_TICK, '0, '0, 1'b0);
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Drove %0d words: %0d ticks, %0d starts, %0d stops, %0d with the unused code.",
             n_ticks + n_starts + n_stops + n_unused, n_ticks, n_starts, n_stops, n_unused);
    $display("Checked %0d fired ids over restarts, stops and a long result stall; %0d mismatched.",
             fires_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      if (pending != 0) $display("%0d fired ids were never delivered.", pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/htw_pkg.sv
sv/htw_in_if.sv
sv/htw_out_if.sv
sv/htw_ram.sv
sv/htw_ctrl.sv
sv/htw_dp.sv
sv/hashed_timing_wheel.sv
sim/htw_fire_checker.sv
sim/tb_hashed_timing_wheel.sv
